// ===== sv/dbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dbrt_pkg - shared constants for the database proxy reply tracker
// Reply state codes, request kinds, command and reply marker bytes, command kinds,
// rewrite modes, sizes.
package dbrt_pkg;

  // Default number of delegate slots
  localparam int unsigned MAX_DELEGATES_DEF = 16;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned DLG_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // Reply state of one delegate
  localparam logic [ST_W-1:0] ST_NONE     = 3'd0;
  localparam logic [ST_W-1:0] ST_GREETING = 3'd1;
  localparam logic [ST_W-1:0] ST_SIMPLE   = 3'd2;
  localparam logic [ST_W-1:0] ST_FIELDS   = 3'd3;
  localparam logic [ST_W-1:0] ST_ROWS     = 3'd4;

  // Request kinds
  localparam logic [CMD_W-1:0] CMD_CLIENT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPLY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_KEEP   = 2'd2;

  // Client command codes
  localparam logic [BYTE_W-1:0] CODE_QUIT       = 8'h01;
  localparam logic [BYTE_W-1:0] CODE_QUERY      = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_FIELD_LIST = 8'h04;

  // Delegate reply markers
  localparam logic [BYTE_W-1:0] MARK_OK  = 8'h00;
  localparam logic [BYTE_W-1:0] MARK_EOF = 8'hfe;
  localparam logic [BYTE_W-1:0] MARK_ERR = 8'hff;

  // Command kinds reported
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_META  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNSUP = 2'd3;

  // How a client command rewrites each active delegate
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_SIMPLE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_QUIT   = 2'd3;

endpackage

// ===== sv/db_reply_tracker.sv =====
// ----------------------------------------------------------------------------
// db_reply_tracker - per-delegate reply tracking for a database proxy
// Steps each delegate's expected reply on client commands, delegate replies
// and keep/drop decisions, and reports the command kind and aggregate status.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: cmd; tdata: delegate, lead_byte,
//          |     |                    |   keep_delegate
//  out_    | out | out_tvalid/tready  | tdata: command_kind .. command_is_auth
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: active delegate count
//
// N is the active delegate count (the configured count capped at
// MAX_DELEGATES). The sequencer first updates the request's own delegate
// (written only for a reply or keep), then walks the first N table entries
// one entry per cycle through a single read/write port, then leaves the
// walk and loads the output register.
// in_tready is high only while the sequencer is idle; a finished result
// waits in the output register and a new request may be taken meanwhile.
// If the output register is still full when the next result is ready, the
// sequencer holds in its last step until out_tready frees it.
// Reset (rst_n low, synchronous) puts every delegate in the greeting state,
// clears all flags and sets the active delegate count to one.
//
module db_reply_tracker #(
  parameter int unsigned MAX_DELEGATES = dbrt_pkg::MAX_DELEGATES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dbrt_pkg::CMD_W-1:0]       in_tuser,    // [1:0] cmd
  input  logic [dbrt_pkg::IN_TDATA_W-1:0]  in_tdata,    // [3:0] delegate,
                                                        // [11:4] lead_byte,
                                                        // [12] keep_delegate,
                                                        // [15:13] zero
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dbrt_pkg::OUT_TDATA_W-1:0] out_tdata,   // [1:0] command_kind,
                                                        // [2] reply_ignored,
                                                        // [3] any_expect_replies,
                                                        // [4] any_expect_commands,
                                                        // [5] any_error,
                                                        // [6] session_done,
                                                        // [7] command_is_auth
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [dbrt_pkg::CFG_W-1:0]       cfg_wr_data  // active delegate count
);

  localparam int unsigned CW = $clog2(MAX_DELEGATES + 1);
  localparam int unsigned NW = (CW > dbrt_pkg::CFG_W) ? CW : dbrt_pkg::CFG_W;
  localparam int unsigned IW = (MAX_DELEGATES > 1) ? $clog2(MAX_DELEGATES) : 1;
  localparam int unsigned SW = dbrt_pkg::ST_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] seq_r, seq_nxt;

  // configuration
  logic [dbrt_pkg::CFG_W-1:0] cfg_cnt_r;
  logic [NW-1:0]              cfg_ext;
  logic [NW-1:0]              n_act;

  // captured request
  logic [dbrt_pkg::CMD_W-1:0]  cmd_r;
  logic [dbrt_pkg::DLG_W-1:0]  dlg_r;
  logic [dbrt_pkg::BYTE_W-1:0] byte_r;
  logic                        keep_r;
  logic [1:0]                  mode_r;
  logic [dbrt_pkg::KIND_W-1:0] kind_r;
  logic                        ign_r, ign_nxt;

  // session flags
  logic quit_r;
  logic await_r, await_nxt;
  logic auth_r;

  // delegate table
  logic [SW-1:0] ent_st_r   [MAX_DELEGATES];
  logic          ent_rows_r [MAX_DELEGATES];
  logic          ent_err_r  [MAX_DELEGATES];

  // table port
  logic [IW-1:0] addr_c;
  logic [SW-1:0] rd_st;
  logic          rd_rows;
  logic          rd_err;
  logic          we_c;
  logic [SW-1:0] wr_st;
  logic          wr_rows;
  logic          wr_err;

  // scan
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          idle_r, idle_nxt;
  logic          err_r, err_nxt;

  // output register
  logic                            out_valid_r;
  logic [dbrt_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic          accept;
  logic [NW-1:0] dlg_ext;
  logic          dlg_act;
  logic          out_load;

  // cap the configured count at the table size
  assign cfg_ext = NW'(cfg_cnt_r);
  assign n_act   = (cfg_ext > NW'(MAX_DELEGATES)) ? NW'(MAX_DELEGATES) : cfg_ext;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (seq_r == S_IDLE);
  assign dlg_ext   = NW'(dlg_r);
  assign dlg_act   = (dlg_ext < n_act);
  assign out_load  = (seq_r == S_OUT) && (!out_valid_r || out_tready);

  // single table port: the update step addresses the request's delegate,
  // the scan addresses the walking counter
  assign addr_c  = (seq_r == S_UPD) ? dlg_ext[IW-1:0] : cnt_r[IW-1:0];
  assign rd_st   = ent_st_r[addr_c];
  assign rd_rows = ent_rows_r[addr_c];
  assign rd_err  = ent_err_r[addr_c];

  always_comb begin
    seq_nxt   = seq_r;
    ign_nxt   = ign_r;
    await_nxt = await_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    idle_nxt  = idle_r;
    err_nxt   = err_r;
    we_c      = 1'b0;
    wr_st     = rd_st;
    wr_rows   = rd_rows;
    wr_err    = rd_err;
    case (seq_r)
      S_IDLE: begin
        if (accept) begin
          seq_nxt  = S_UPD;
          ign_nxt  = 1'b0;
          cnt_nxt  = '0;
          busy_nxt = 1'b0;
          idle_nxt = 1'b0;
          err_nxt  = 1'b0;
          // an authentication packet clears the pending flag
          if (in_tuser == dbrt_pkg::CMD_CLIENT) begin
            await_nxt = 1'b0;
          end
        end
      end
      S_UPD: begin
        seq_nxt = S_SCAN;
        if (cmd_r == dbrt_pkg::CMD_REPLY) begin
          if (!dlg_act || rd_st == dbrt_pkg::ST_NONE) begin
            ign_nxt = 1'b1;
          end else if (byte_r == dbrt_pkg::MARK_ERR) begin
            we_c    = 1'b1;
            wr_st   = dbrt_pkg::ST_NONE;
            wr_rows = 1'b0;
            wr_err  = 1'b1;
          end else begin
            we_c = 1'b1;
            case (rd_st)
              dbrt_pkg::ST_GREETING: begin
                await_nxt = 1'b1;
                wr_st     = dbrt_pkg::ST_NONE;
              end
              dbrt_pkg::ST_SIMPLE: begin
                wr_st = (byte_r == dbrt_pkg::MARK_OK) ? dbrt_pkg::ST_NONE
                                                      : dbrt_pkg::ST_FIELDS;
              end
              dbrt_pkg::ST_FIELDS: begin
                if (byte_r == dbrt_pkg::MARK_EOF) begin
                  wr_st = rd_rows ? dbrt_pkg::ST_ROWS : dbrt_pkg::ST_NONE;
                end
              end
              dbrt_pkg::ST_ROWS: begin
                if (byte_r == dbrt_pkg::MARK_EOF) begin
                  wr_st = dbrt_pkg::ST_NONE;
                end
              end
              default: begin
                wr_st = rd_st;
              end
            endcase
          end
        end else if (cmd_r == dbrt_pkg::CMD_KEEP) begin
          // drop the delegate
          if (!keep_r && dlg_act) begin
            we_c  = 1'b1;
            wr_st = dbrt_pkg::ST_NONE;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < n_act) begin
          // a client command rewrites each active entry as it passes
          if (mode_r != dbrt_pkg::MODE_HOLD) begin
            we_c    = 1'b1;
            wr_err  = 1'b0;
            wr_rows = (mode_r == dbrt_pkg::MODE_QUERY);
            wr_st   = (mode_r == dbrt_pkg::MODE_QUIT) ? dbrt_pkg::ST_NONE
                                                      : dbrt_pkg::ST_SIMPLE;
          end
          busy_nxt = busy_r | (wr_st != dbrt_pkg::ST_NONE);
          idle_nxt = idle_r | (wr_st == dbrt_pkg::ST_NONE);
          err_nxt  = err_r | wr_err;
          cnt_nxt  = cnt_r + NW'(1);
        end else begin
          seq_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          seq_nxt = S_IDLE;
        end
      end
      default: begin
        seq_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer, flags and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= S_IDLE;
      cfg_cnt_r <= dbrt_pkg::CFG_W'(1);
      quit_r    <= 1'b0;
      await_r   <= 1'b0;
      auth_r    <= 1'b0;
      ign_r     <= 1'b0;
      cnt_r     <= '0;
      busy_r    <= 1'b0;
      idle_r    <= 1'b0;
      err_r     <= 1'b0;
      mode_r    <= dbrt_pkg::MODE_HOLD;
    end else begin
      seq_r   <= seq_nxt;
      await_r <= await_nxt;
      ign_r   <= ign_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      idle_r  <= idle_nxt;
      err_r   <= err_nxt;
      if (cfg_wr_en) begin
        cfg_cnt_r <= cfg_wr_data;
      end
      if (accept) begin
        mode_r <= dbrt_pkg::MODE_HOLD;
        if (in_tuser == dbrt_pkg::CMD_CLIENT) begin
          auth_r <= await_r;
          if (await_r) begin
            mode_r <= dbrt_pkg::MODE_SIMPLE;
          end else if (in_tdata[11:4] == dbrt_pkg::CODE_QUIT) begin
            mode_r <= dbrt_pkg::MODE_QUIT;
            quit_r <= 1'b1;
          end else if (in_tdata[11:4] == dbrt_pkg::CODE_QUERY) begin
            mode_r <= dbrt_pkg::MODE_QUERY;
          end else begin
            mode_r <= dbrt_pkg::MODE_SIMPLE;
          end
        end
      end
    end
  end

  // request capture; classify a client command at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_tuser;
      dlg_r  <= in_tdata[3:0];
      byte_r <= in_tdata[11:4];
      keep_r <= in_tdata[12];
      kind_r <= dbrt_pkg::KIND_OTHER;
      if (in_tuser == dbrt_pkg::CMD_CLIENT && !await_r) begin
        case (in_tdata[11:4])
          dbrt_pkg::CODE_QUIT:       kind_r <= dbrt_pkg::KIND_OTHER;
          dbrt_pkg::CODE_QUERY:      kind_r <= dbrt_pkg::KIND_QUERY;
          dbrt_pkg::CODE_FIELD_LIST: kind_r <= dbrt_pkg::KIND_META;
          default:                   kind_r <= dbrt_pkg::KIND_UNSUP;
        endcase
      end
    end
  end

  // delegate table: reset puts every slot in greeting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DELEGATES; i++) begin
        ent_st_r[i]   <= dbrt_pkg::ST_GREETING;
        ent_rows_r[i] <= 1'b0;
        ent_err_r[i]  <= 1'b0;
      end
    end else if (we_c) begin
      ent_st_r[addr_c]   <= wr_st;
      ent_rows_r[addr_c] <= wr_rows;
      ent_err_r[addr_c]  <= wr_err;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {auth_r, quit_r, err_r, !quit_r && idle_r, !quit_r && busy_r,
                     ign_r, kind_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
